// ===== rtl/core/aqs_pkg.sv =====
// Shared types and constants for the air quality scoring pipeline.
// Depends on nothing; every other file takes its names by scope.
`timescale 1ns / 1ps

package aqs_pkg;

	typedef struct packed {
		logic signed [14:0] temperature;
		logic [13:0]        humidity;
		logic [21:0]        carbon_dioxide;
		logic [21:0]        volatile_organics;
		logic [19:0]        particulates;
	} aqs_in_t;

	typedef struct packed {
		logic [2:0] temperature_index;
		logic [2:0] humidity_index;
		logic [2:0] co2_index;
		logic [2:0] voc_index;
		logic [2:0] dust_index;
		logic [6:0] score;
		logic [1:0] colour_class;
	} aqs_out_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} aqs_adv_t;

	localparam logic [1:0] COLOUR_GREEN  = 2'd0;
	localparam logic [1:0] COLOUR_AMBER  = 2'd1;
	localparam logic [1:0] COLOUR_PURPLE = 2'd2;

	localparam int TEMP_LO  = 1800;
	localparam int TEMP_HI  = 2600;
	localparam int HUM_LO   = 3000;
	localparam int HUM_HI   = 6000;
	localparam int CO2_HI   = 100000;
	localparam int VOC_HI   = 33300;
	localparam int DUST_HI  = 1200;

	localparam int TEMP_STEP = 200;
	localparam int HUM_STEP  = 1000;
	localparam int CO2_STEP  = 40000;
	localparam int VOC_STEP  = 33300;
	localparam int DUST_STEP = 1200;

	localparam int TEMP_FULL = 1200;
	localparam int HUM_FULL  = 4000;
	localparam int CO2_FULL  = 80000;
	localparam int VOC_FULL  = 100000;
	localparam int DUST_FULL = 6000;

	localparam int TEMP_MAX = 8;
	localparam int HUM_MAX  = 8;
	localparam int CO2_MAX  = 25;
	localparam int VOC_MAX  = 25;
	localparam int DUST_MAX = 34;

	localparam int SCORE_TOP   = 100;
	localparam int GREEN_FLOOR = 80;
	localparam int AMBER_FLOOR = 60;

	localparam int DIST_T_W = 15;
	localparam int DIST_H_W = 14;
	localparam int DIST_C_W = 22;
	localparam int DIST_V_W = 22;
	localparam int DIST_D_W = 20;

	localparam int PEN_T_W = $clog2(TEMP_MAX + 1);
	localparam int PEN_H_W = $clog2(HUM_MAX + 1);
	localparam int PEN_C_W = $clog2(CO2_MAX + 1);
	localparam int PEN_V_W = $clog2(VOC_MAX + 1);
	localparam int PEN_D_W = $clog2(DUST_MAX + 1);

	localparam int RECIP_SHIFT = 40;

endpackage

// ===== rtl/core/aqs_lane.sv =====
// One sensor lane: severity index and rounded penalty from a band distance.
// Stages two and three of the pipeline; uses aqs_pkg for the advance struct.
`timescale 1ns / 1ps

module aqs_lane #(
	parameter int DW   = 15,
	parameter int STEP = 200,
	parameter int FULL = 1200,
	parameter int MAX  = 8
) (
	input  logic                      clk,
	input  aqs_pkg::aqs_adv_t         adv,
	input  logic [DW-1:0]             distance,
	output logic [2:0]                idx,
	output logic [$clog2(MAX+1)-1:0]  pen
);

	localparam int PW    = $clog2(MAX + 1);
	localparam int CW    = $clog2(FULL + 1);
	localparam int NW    = $clog2(MAX * FULL + FULL / 2 + 1);
	localparam int SHIFT = aqs_pkg::RECIP_SHIFT;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + 64'(FULL) - 64'd1) / 64'(FULL);
	localparam int RW    = $clog2(RECIP + 1);
	localparam int XW    = (NW + RW > SHIFT + PW) ? NW + RW : SHIFT + PW;

	logic [CW-1:0] clamp;
	logic [2:0]    idx_c;
	logic [2:0]    idx_s2;
	logic [NW-1:0] num_s2;
	logic [2:0]    idx_s3;
	logic [XW-1:0] prod_s3;

	always_comb begin
		idx_c = 3'd0;
		for (int k = 0; k < 4; k++) begin
			if (32'(distance) > 32'(k * STEP)) begin
				idx_c = idx_c + 3'd1;
			end
		end
		clamp = (32'(distance) >= 32'(FULL)) ? CW'(FULL) : CW'(distance);
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			idx_s2 <= idx_c;
			num_s2 <= NW'(clamp) * NW'(MAX) + NW'(FULL / 2);
		end
		if (adv.s3) begin
			idx_s3  <= idx_s2;
			prod_s3 <= XW'(num_s2) * XW'(RECIP);
		end
	end

	assign idx = idx_s3;
	assign pen = prod_s3[SHIFT +: PW];

endmodule

// ===== rtl/core/aqs_band.sv =====
// First stage: distances of the five readings outside their good bands.
// Uses aqs_pkg for the input struct, band edges and distance widths.
`timescale 1ns / 1ps

module aqs_band (
	input  logic                                 clk,
	input  logic                                 adv,
	input  aqs_pkg::aqs_in_t                     item,
	output logic [aqs_pkg::DIST_T_W-1:0]         dist_t,
	output logic [aqs_pkg::DIST_H_W-1:0]         dist_h,
	output logic [aqs_pkg::DIST_C_W-1:0]         dist_c,
	output logic [aqs_pkg::DIST_V_W-1:0]         dist_v,
	output logic [aqs_pkg::DIST_D_W-1:0]         dist_d
);

	logic signed [15:0] t_ext;
	logic [aqs_pkg::DIST_T_W-1:0] dt_c;
	logic [aqs_pkg::DIST_H_W-1:0] dh_c;
	logic [aqs_pkg::DIST_C_W-1:0] dc_c;
	logic [aqs_pkg::DIST_V_W-1:0] dv_c;
	logic [aqs_pkg::DIST_D_W-1:0] dd_c;
	logic [aqs_pkg::DIST_T_W-1:0] dist_t_s1;
	logic [aqs_pkg::DIST_H_W-1:0] dist_h_s1;
	logic [aqs_pkg::DIST_C_W-1:0] dist_c_s1;
	logic [aqs_pkg::DIST_V_W-1:0] dist_v_s1;
	logic [aqs_pkg::DIST_D_W-1:0] dist_d_s1;

	always_comb begin
		t_ext = 16'(item.temperature);
		if (t_ext < 16'sd1800) begin
			dt_c = aqs_pkg::DIST_T_W'(16'(aqs_pkg::TEMP_LO) - t_ext);
		end else if (t_ext > 16'(aqs_pkg::TEMP_HI)) begin
			dt_c = aqs_pkg::DIST_T_W'(t_ext - 16'(aqs_pkg::TEMP_HI));
		end else begin
			dt_c = '0;
		end
		if (item.humidity < 14'(aqs_pkg::HUM_LO)) begin
			dh_c = 14'(aqs_pkg::HUM_LO) - item.humidity;
		end else if (item.humidity > 14'(aqs_pkg::HUM_HI)) begin
			dh_c = item.humidity - 14'(aqs_pkg::HUM_HI);
		end else begin
			dh_c = '0;
		end
		dc_c = (item.carbon_dioxide > 22'(aqs_pkg::CO2_HI)) ?
			item.carbon_dioxide - 22'(aqs_pkg::CO2_HI) : '0;
		dv_c = (item.volatile_organics > 22'(aqs_pkg::VOC_HI)) ?
			item.volatile_organics - 22'(aqs_pkg::VOC_HI) : '0;
		dd_c = (item.particulates > 20'(aqs_pkg::DUST_HI)) ?
			item.particulates - 20'(aqs_pkg::DUST_HI) : '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_t_s1 <= dt_c;
			dist_h_s1 <= dh_c;
			dist_c_s1 <= dc_c;
			dist_v_s1 <= dv_c;
			dist_d_s1 <= dd_c;
		end
	end

	assign dist_t = dist_t_s1;
	assign dist_h = dist_h_s1;
	assign dist_c = dist_c_s1;
	assign dist_v = dist_v_s1;
	assign dist_d = dist_d_s1;

endmodule

// ===== rtl/core/air_quality_score.sv =====
// Top level of the air quality scoring pipeline: handshake, valid bits,
// penalty sum, score and colour class. Uses aqs_pkg, aqs_band and aqs_lane.
//
//   channel  | direction | handshake                     | payload
//   sensor   | in        | sensor_valid / sensor_stall   | aqs_pkg::aqs_in_t
//   result   | out       | result_valid / result_stall   | aqs_pkg::aqs_out_t
//
// Four register stages: band distances, index and scaled numerator,
// reciprocal product, then penalty sum with score and colour.
// One item enters every cycle while the output moves.
// A stall on the result side holds a full stage only when every stage after it is full; an empty stage still fills.
// Reset clears the valid bits only.
`timescale 1ns / 1ps

module air_quality_score (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sensor_valid,
	output logic               sensor_stall,
	input  aqs_pkg::aqs_in_t   sensor,
	output logic               result_valid,
	input  logic               result_stall,
	output aqs_pkg::aqs_out_t  result
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv4;
	aqs_pkg::aqs_adv_t adv;
	aqs_pkg::aqs_out_t result_s4;

	logic [aqs_pkg::DIST_T_W-1:0] dist_t;
	logic [aqs_pkg::DIST_H_W-1:0] dist_h;
	logic [aqs_pkg::DIST_C_W-1:0] dist_c;
	logic [aqs_pkg::DIST_V_W-1:0] dist_v;
	logic [aqs_pkg::DIST_D_W-1:0] dist_d;

	logic [2:0] idx_t, idx_h, idx_c, idx_v, idx_d;
	logic [aqs_pkg::PEN_T_W-1:0] pen_t;
	logic [aqs_pkg::PEN_H_W-1:0] pen_h;
	logic [aqs_pkg::PEN_C_W-1:0] pen_c;
	logic [aqs_pkg::PEN_V_W-1:0] pen_v;
	logic [aqs_pkg::PEN_D_W-1:0] pen_d;
	logic [6:0] pen_sum;
	logic [6:0] score_c;
	logic [1:0] colour_c;

	always_comb begin
		adv4   = !result_stall || !v_s4;
		adv.s3 = adv4 || !v_s3;
		adv.s2 = adv.s3 || !v_s2;
		adv1   = adv.s2 || !v_s1;
	end

	assign sensor_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= sensor_valid;
			end
			if (adv.s2) begin
				v_s2 <= v_s1;
			end
			if (adv.s3) begin
				v_s3 <= v_s2;
			end
			if (adv4) begin
				v_s4 <= v_s3;
			end
		end
	end

	aqs_band u_band (
		.clk    (clk),
		.adv    (adv1),
		.item   (sensor),
		.dist_t (dist_t),
		.dist_h (dist_h),
		.dist_c (dist_c),
		.dist_v (dist_v),
		.dist_d (dist_d)
	);

	aqs_lane #(
		.DW   (aqs_pkg::DIST_T_W),
		.STEP (aqs_pkg::TEMP_STEP),
		.FULL (aqs_pkg::TEMP_FULL),
		.MAX  (aqs_pkg::TEMP_MAX)
	) u_lane_t (.clk(clk), .adv(adv), .distance(dist_t), .idx(idx_t), .pen(pen_t));

	aqs_lane #(
		.DW   (aqs_pkg::DIST_H_W),
		.STEP (aqs_pkg::HUM_STEP),
		.FULL (aqs_pkg::HUM_FULL),
		.MAX  (aqs_pkg::HUM_MAX)
	) u_lane_h (.clk(clk), .adv(adv), .distance(dist_h), .idx(idx_h), .pen(pen_h));

	aqs_lane #(
		.DW   (aqs_pkg::DIST_C_W),
		.STEP (aqs_pkg::CO2_STEP),
		.FULL (aqs_pkg::CO2_FULL),
		.MAX  (aqs_pkg::CO2_MAX)
	) u_lane_c (.clk(clk), .adv(adv), .distance(dist_c), .idx(idx_c), .pen(pen_c));

	aqs_lane #(
		.DW   (aqs_pkg::DIST_V_W),
		.STEP (aqs_pkg::VOC_STEP),
		.FULL (aqs_pkg::VOC_FULL),
		.MAX  (aqs_pkg::VOC_MAX)
	) u_lane_v (.clk(clk), .adv(adv), .distance(dist_v), .idx(idx_v), .pen(pen_v));

	aqs_lane #(
		.DW   (aqs_pkg::DIST_D_W),
		.STEP (aqs_pkg::DUST_STEP),
		.FULL (aqs_pkg::DUST_FULL),
		.MAX  (aqs_pkg::DUST_MAX)
	) u_lane_d (.clk(clk), .adv(adv), .distance(dist_d), .idx(idx_d), .pen(pen_d));

	always_comb begin
		pen_sum = 7'(pen_t) + 7'(pen_h) + 7'(pen_c) + 7'(pen_v) + 7'(pen_d);
		score_c = (pen_sum < 7'(aqs_pkg::SCORE_TOP)) ?
			7'(aqs_pkg::SCORE_TOP) - pen_sum : 7'd0;
		priority if (score_c >= 7'(aqs_pkg::GREEN_FLOOR)) begin
			colour_c = aqs_pkg::COLOUR_GREEN;
		end else if (score_c >= 7'(aqs_pkg::AMBER_FLOOR)) begin
			colour_c = aqs_pkg::COLOUR_AMBER;
		end else begin
			colour_c = aqs_pkg::COLOUR_PURPLE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			result_s4.temperature_index <= idx_t;
			result_s4.humidity_index    <= idx_h;
			result_s4.co2_index         <= idx_c;
			result_s4.voc_index         <= idx_v;
			result_s4.dust_index        <= idx_d;
			result_s4.score             <= score_c;
			result_s4.colour_class      <= colour_c;
		end
	end

	assign result_valid = v_s4;
	assign result       = result_s4;

endmodule

// ===== test/tb_air_quality_score.sv =====
// Self-checking testbench for air_quality_score: drives sensor readings
// with random idling and checks every score against an internal predictor.
// Depends on aqs_pkg and the air_quality_score RTL.
`timescale 1ns / 1ps

module tb_air_quality_score;

	class aqs_scoreboard;
		aqs_pkg::aqs_out_t expected_scores[$];
		int fail_count;

		function new();
			fail_count = 0;
		endfunction

		static function int unsigned band_steps(longint span, longint step);
			longint idx;
			if (span <= 0)
				return 0;
			idx = (span + step - 1) / step;
			return (idx > 4) ? 4 : int'(idx);
		endfunction

		static function int unsigned band_penalty(longint span, longint full, longint top);
			if (span <= 0)
				return 0;
			if (span >= full)
				return int'(top);
			return int'((span * top + full / 2) / full);
		endfunction

		static function aqs_pkg::aqs_out_t score_reading(aqs_pkg::aqs_in_t r);
			aqs_pkg::aqs_out_t o;
			longint t, h, c, v, p;
			longint dt, dh, dc, dv, dd;
			int unsigned total, points;
			t = longint'($signed(r.temperature));
			h = longint'(r.humidity);
			c = longint'(r.carbon_dioxide);
			v = longint'(r.volatile_organics);
			p = longint'(r.particulates);
			dt = (t < 1800) ? 1800 - t : (t > 2600) ? t - 2600 : 0;
			dh = (h < 3000) ? 3000 - h : (h > 6000) ? h - 6000 : 0;
			dc = (c > 100000) ? c - 100000 : 0;
			dv = (v > 33300) ? v - 33300 : 0;
			dd = (p > 1200) ? p - 1200 : 0;
			o.temperature_index = 3'(band_steps(dt, 200));
			o.humidity_index    = 3'(band_steps(dh, 1000));
			o.co2_index         = 3'(band_steps(dc, 40000));
			o.voc_index         = 3'(band_steps(dv, 33300));
			o.dust_index        = 3'(band_steps(dd, 1200));
			total = band_penalty(dt, 1200, 8) + band_penalty(dh, 4000, 8)
				+ band_penalty(dc, 80000, 25) + band_penalty(dv, 100000, 25)
				+ band_penalty(dd, 6000, 34);
			points = (total < 100) ? 100 - total : 0;
			o.score = 7'(points);
			if (points >= 80)
				o.colour_class = aqs_pkg::COLOUR_GREEN;
			else if (points >= 60)
				o.colour_class = aqs_pkg::COLOUR_AMBER;
			else
				o.colour_class = aqs_pkg::COLOUR_PURPLE;
			return o;
		endfunction

		function void note_reading(aqs_pkg::aqs_in_t r);
			expected_scores.push_back(score_reading(r));
		endfunction

		function void check_result(aqs_pkg::aqs_out_t got);
			aqs_pkg::aqs_out_t want;
			bit bad;
			if (expected_scores.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: score %0d class %0d", got.score,
						got.colour_class);
				return;
			end
			want = expected_scores.pop_front();
			bad = (got.temperature_index != want.temperature_index)
				|| (got.humidity_index != want.humidity_index)
				|| (got.co2_index != want.co2_index)
				|| (got.voc_index != want.voc_index)
				|| (got.dust_index != want.dust_index)
				|| (got.score != want.score)
				|| (got.colour_class != want.colour_class);
			if (bad) begin
				fail_count++;
				if (fail_count <= 10)
					$display({"mismatch: expected idx %0d %0d %0d %0d %0d ",
						"score %0d class %0d, got idx %0d %0d %0d %0d %0d ",
						"score %0d class %0d"},
						want.temperature_index, want.humidity_index, want.co2_index,
						want.voc_index, want.dust_index, want.score, want.colour_class,
						got.temperature_index, got.humidity_index, got.co2_index,
						got.voc_index, got.dust_index, got.score, got.colour_class);
			end
		endfunction

		function int pending();
			return expected_scores.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               sensor_valid;
	logic               sensor_stall;
	aqs_pkg::aqs_in_t   sensor;
	logic               result_valid;
	logic               result_stall;
	aqs_pkg::aqs_out_t  result;

	aqs_scoreboard sb = new();
	bit quiet = 1'b0;
	bit long_hold_req = 1'b0;

	air_quality_score DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sensor_valid (sensor_valid),
		.sensor_stall (sensor_stall),
		.sensor       (sensor),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (sensor_valid && !sensor_stall)
				sb.note_reading(sensor);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				result_stall <= 1'b1;
				repeat (80) @(posedge clk);
				result_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb_air_quality_score: done, errors");
		$finish;
	end

	function automatic aqs_pkg::aqs_in_t make_reading(int t, int h, int c, int v, int d);
		aqs_pkg::aqs_in_t r;
		r.temperature       = 15'(t);
		r.humidity          = 14'(h);
		r.carbon_dioxide    = 22'(c);
		r.volatile_organics = 22'(v);
		r.particulates      = 20'(d);
		return r;
	endfunction

	function automatic aqs_pkg::aqs_in_t random_reading();
		logic [95:0] raw;
		aqs_pkg::aqs_in_t r;
		if ($urandom_range(0, 3) == 0) begin
			raw = {$urandom, $urandom, $urandom};
			return aqs_pkg::aqs_in_t'(raw[$bits(aqs_pkg::aqs_in_t)-1:0]);
		end
		r.temperature = $urandom_range(0, 1) ? 15'(int'($urandom_range(1400, 3000)))
			: 15'(int'($urandom_range(0, 25000)) - 10000);
		r.humidity = $urandom_range(0, 1) ? 14'($urandom_range(2000, 7000))
			: 14'($urandom_range(0, 10000));
		r.carbon_dioxide = $urandom_range(0, 1) ? 22'($urandom_range(80000, 200000))
			: 22'($urandom_range(0, 4000000));
		r.volatile_organics = $urandom_range(0, 1) ? 22'($urandom_range(20000, 150000))
			: 22'($urandom_range(0, 4000000));
		r.particulates = $urandom_range(0, 1) ? 20'($urandom_range(0, 9000))
			: 20'($urandom_range(0, 1000000));
		return r;
	endfunction

	function automatic int sender_gap();
		if (quiet || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(1, 5);
	endfunction

	task automatic offer_reading(input aqs_pkg::aqs_in_t r, input int gap);
		if (gap > 0) begin
			sensor_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sensor_valid <= 1'b1;
		sensor <= r;
		@(posedge clk);
		while (sensor_stall) @(posedge clk);
	endtask

	initial begin
		aqs_pkg::aqs_in_t directed[$];
		int i;
		arst_n <= 1'b0;
		sensor_valid <= 1'b0;
		sensor <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(make_reading(2200, 4500, 0, 0, 0));
		directed.push_back(make_reading(1800, 3000, 100000, 33300, 1200));
		directed.push_back(make_reading(2600, 6000, 100000, 33300, 1200));
		directed.push_back(make_reading(1799, 2999, 100001, 33301, 1201));
		directed.push_back(make_reading(2601, 6001, 140000, 66600, 2400));
		directed.push_back(make_reading(-16384, 0, 4194303, 4194303, 1048575));
		directed.push_back(make_reading(16383, 16383, 4194303, 4194303, 1048575));
		directed.push_back(make_reading(-10000, 10000, 4000000, 4000000, 1000000));
		directed.push_back(make_reading(15000, 5000, 0, 0, 0));
		directed.push_back(make_reading(2675, 4500, 0, 0, 0));
		directed.push_back(make_reading(2200, 4500, 140000, 83300, 0));
		directed.push_back(make_reading(2200, 4500, 0, 0, 4700));
		directed.push_back(make_reading(3500, 4500, 0, 0, 7200));
		directed.push_back(make_reading(3600, 4500, 0, 0, 7200));
		directed.push_back(make_reading(1000, 1000, 180000, 133300, 7200));
		directed.push_back(make_reading(2200, 8000, 100000, 33300, 1200));
		directed.push_back(make_reading(-1, 3000, 180001, 133301, 7201));
		directed.push_back(make_reading(2200, 4500, 120000, 50000, 3000));
		directed.push_back(make_reading(2200, 4500, 99999, 33299, 1199));
		directed.push_back(make_reading(2800, 2500, 150000, 60000, 4000));
		foreach (directed[k])
			offer_reading(directed[k], sender_gap());

		sensor_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);

		long_hold_req = 1'b1;
		for (i = 0; i < 40; i++)
			offer_reading(random_reading(), 0);

		for (i = 0; i < 1590; i++) begin
			if (i == 1300)
				quiet = 1'b1;
			offer_reading(random_reading(), sender_gap());
		end
		sensor_valid <= 1'b0;
		@(posedge clk);

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.fail_count == 0)
			$display("tb_air_quality_score: done, clean");
		else
			$display("tb_air_quality_score: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/aqs_pkg.sv
rtl/core/aqs_lane.sv
rtl/core/aqs_band.sv
rtl/core/air_quality_score.sv
test/tb_air_quality_score.sv
